// ===== hdl/cqe_pkg.sv =====
`default_nettype none

package cqe_pkg;

   // Storage geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int LIM_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   // Operation codes carried in the kind field
   localparam logic [1:0] KIND_ENQ  = 2'd0;
   localparam logic [1:0] KIND_DEQ  = 2'd1;
   localparam logic [1:0] KIND_DUMP = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;

   // One request beat
   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] data_in;
   } req_type;

   // One result beat
   typedef struct packed {
      logic signed [DATA_W-1:0] data_out;
      logic [1:0]               status;
      logic                     last;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic cfg_wr;
      logic enq;
      logic deq;
      logic dump_empty;
      logic dump_start;
      logic dump_emit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic dump_fin;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/cqe_ctrl.sv =====
`default_nettype none

module cqe_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire cqe_pkg::stat_type stat,
   output cqe_pkg::cmd_type       cmd
);
   import cqe_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic req_fire;
   logic load;

   // The output register is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) && out_free && !csr_valid;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Command decode and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.cfg_wr = csr_valid;
            if (req_fire) begin
               case (req_kind)
                  KIND_ENQ: cmd.enq = 1'b1;
                  KIND_DEQ: cmd.deq = 1'b1;
                  KIND_DUMP: begin
                     if (stat.empty) begin
                        cmd.dump_empty = 1'b1;
                     end else begin
                        cmd.dump_start = 1'b1;
                        state_in       = S_DUMP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DUMP: begin
            if (out_free) begin
               cmd.dump_emit = 1'b1;
               if (stat.dump_fin) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // A result beat is loaded by enqueue, dequeue and every dump beat
   assign load         = cmd.enq || cmd.deq || cmd.dump_empty || cmd.dump_emit;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // No new request is taken while a dump is running
   a_no_req_in_dump: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP) |-> !req_ready)
      else $error("request accepted during dump");

   // A dump start always leads into the dump state
   a_dump_enters: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_start |=> (state_ff == S_DUMP))
      else $error("dump start did not enter dump state");

   // A result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== hdl/cqe_dpath.sv =====
`default_nettype none

module cqe_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cqe_pkg::cmd_type            cmd,
   input  wire logic signed [31:0]          req_data_in,
   input  wire logic [cqe_pkg::LIM_W-1:0]   csr_data,
   output cqe_pkg::stat_type                stat,
   output cqe_pkg::rsp_type                 rsp_data
);
   import cqe_pkg::*;

   logic signed [DATA_W-1:0] slot_ff [DEPTH];
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic                     empty_ff, empty_in;
   logic [LIM_W-1:0]         limit_ff, limit_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_data;
   logic [IDX_W-1:0]         tail_next;
   logic [IDX_W-1:0]         head_next;
   logic                     full;
   logic                     dump_fin;

   // Step an index by one, wrapping at the configured limit
   function automatic logic [IDX_W-1:0] adv_idx(input logic [IDX_W-1:0] idx,
                                                input logic [LIM_W-1:0] lim);
      logic [LIM_W-1:0] nxt;
      nxt = {1'b0, idx} + LIM_W'(1);
      return (nxt >= lim) ? '0 : nxt[IDX_W-1:0];
   endfunction

   assign tail_next = adv_idx(tail_ff, limit_ff);
   assign head_next = adv_idx(head_ff, limit_ff);
   assign full      = (tail_next == head_ff);
   assign dump_fin  = (idx_ff == tail_ff) || (({1'b0, cnt_ff} + LIM_W'(1)) == limit_ff);

   // Single read port: head for dequeue, walking index for dump
   assign rd_addr = cmd.dump_emit ? idx_ff : head_ff;
   assign rd_data = slot_ff[rd_addr];

   assign stat.empty    = empty_ff;
   assign stat.dump_fin = dump_fin;
   assign rsp_data      = rsp_ff;

   // Queue pointers, limit and result beat
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      limit_in = limit_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_next;
      if (cmd.cfg_wr) begin
         if (csr_data == '0) begin
            limit_in = LIM_W'(1);
         end else if (csr_data > LIM_W'(DEPTH)) begin
            limit_in = LIM_W'(DEPTH);
         end else begin
            limit_in = csr_data;
         end
         head_in  = '0;
         tail_in  = '0;
         empty_in = 1'b1;
      end
      if (cmd.enq) begin
         rsp_in = '{data_out: '0, status: STAT_OK, last: 1'b1};
         if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            wr_en    = 1'b1;
            wr_addr  = '0;
         end else if (full) begin
            rsp_in.status = STAT_OVERFLOW;
         end else begin
            tail_in = tail_next;
            wr_en   = 1'b1;
         end
      end
      if (cmd.deq) begin
         if (empty_ff) begin
            rsp_in = '{data_out: '0, status: STAT_EMPTY, last: 1'b1};
         end else begin
            rsp_in = '{data_out: rd_data, status: STAT_OK, last: 1'b1};
            if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else begin
               head_in = head_next;
            end
         end
      end
      if (cmd.dump_empty) begin
         rsp_in = '{data_out: '0, status: STAT_EMPTY, last: 1'b1};
      end
      if (cmd.dump_start) begin
         idx_in = head_ff;
         cnt_in = '0;
      end
      if (cmd.dump_emit) begin
         rsp_in = '{data_out: rd_data, status: STAT_OK, last: dump_fin};
         idx_in = adv_idx(idx_ff, limit_ff);
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   // Slot storage, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= req_data_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         limit_ff <= LIM_W'(DEPTH);
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         limit_ff <= limit_in;
      end
   end

   // An empty queue always has both pointers at slot zero
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty queue with pointers away from zero");

   // Both pointers stay inside the configured length
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, head_ff} < limit_ff) && ({1'b0, tail_ff} < limit_ff))
      else $error("pointer beyond limit");

   // The stored limit is always saturated into range
   a_limit_range: assert property (@(posedge clock) disable iff (reset)
      (limit_ff != '0) && (limit_ff <= LIM_W'(DEPTH)))
      else $error("limit out of range");

endmodule

`default_nettype wire

// ===== hdl/circular_queue_engine_unit.sv =====
// Channel   Direction  Handshake                Beat contents
// req_      in         req_valid / req_ready    req_data: kind, data_in
// rsp_      out        rsp_valid / rsp_ready    rsp_data: data_out, status, last
// csr_      in         csr_valid / csr_ready    csr_data: queue_limit
//
// An enqueue or dequeue can be accepted every cycle while results are taken, no
// dump is running and no limit write is waiting. A dump first sets up the walk,
// then reads one held word at a time through the single slot read port.
// Reset is synchronous; slot contents are not cleared.
// A stalled result holds in the output register and blocks new requests.
`default_nettype none

module circular_queue_engine_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire cqe_pkg::req_type          req_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output cqe_pkg::rsp_type               rsp_data,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [cqe_pkg::LIM_W-1:0] csr_data
);
   import cqe_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencing and handshakes
   cqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_data.kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, pointers and result register
   cqe_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data_in (req_data.data_in),
      .csr_data    (csr_data),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/tb_circular_queue_engine_unit.sv =====
module tb_circular_queue_engine_unit;

   import cqe_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 90;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIM_W-1:0] csr_data = '0;

   circular_queue_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Beats waiting to be offered, and the results the queue should give back.
   req_type pending_req[$];
   rsp_type expected_rsp[$];

   int requests_queued = 0;
   int requests_taken = 0;
   int limit_writes = 0;
   int random_items = 0;
   int beats_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // Our own copy of the ring: stored words, indices, empty flag and limit.
   logic signed [DATA_W-1:0] ring_words [DEPTH];
   logic [IDX_W-1:0] ring_head;
   logic [IDX_W-1:0] ring_tail;
   logic ring_empty;
   int ring_limit;

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP)
         $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void ring_clear();
      ring_head = '0;
      ring_tail = '0;
      ring_empty = 1'b1;
   endfunction

   function automatic void ring_set_limit(input logic [LIM_W-1:0] value);
      // Zero behaves as one slot; anything past the storage saturates.
      if (value == 0)
         ring_limit = 1;
      else if (int'(value) > DEPTH)
         ring_limit = DEPTH;
      else
         ring_limit = int'(value);
      ring_clear();
   endfunction

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      int n;
      n = int'(idx) + 1;
      return (n >= ring_limit) ? '0 : n[IDX_W-1:0];
   endfunction

   function automatic void expect_beat(input logic signed [DATA_W-1:0] word,
                                       input logic [1:0] status, input logic last);
      rsp_type beat;
      beat.data_out = word;
      beat.status = status;
      beat.last = last;
      expected_rsp.push_back(beat);
   endfunction

   // Work out every result beat that one accepted request will cause.
   function automatic void ring_apply(input req_type item);
      logic [IDX_W-1:0] idx;
      logic fin;
      case (item.kind)
         KIND_ENQ: begin
            if (ring_empty) begin
               ring_head = '0;
               ring_tail = '0;
               ring_empty = 1'b0;
               ring_words[0] = item.data_in;
               expect_beat('0, STAT_OK, 1'b1);
            end else if (ring_next(ring_tail) == ring_head) begin
               expect_beat('0, STAT_OVERFLOW, 1'b1);
            end else begin
               ring_tail = ring_next(ring_tail);
               ring_words[ring_tail] = item.data_in;
               expect_beat('0, STAT_OK, 1'b1);
            end
         end
         KIND_DEQ: begin
            if (ring_empty) begin
               expect_beat('0, STAT_EMPTY, 1'b1);
            end else begin
               expect_beat(ring_words[ring_head], STAT_OK, 1'b1);
               if (ring_head == ring_tail)
                  ring_clear();
               else
                  ring_head = ring_next(ring_head);
            end
         end
         KIND_DUMP: begin
            if (ring_empty) begin
               expect_beat('0, STAT_EMPTY, 1'b1);
            end else begin
               idx = ring_head;
               for (int k = 0; k < ring_limit; k++) begin
                  fin = (idx == ring_tail) || (k + 1 == ring_limit);
                  expect_beat(ring_words[idx], STAT_OK, fin);
                  if (fin)
                     break;
                  idx = ring_next(idx);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            req_data <= pending_req.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: a rotating stall pattern, replaced whenever its random age runs out.
   logic [15:0] stall_pattern = '1;
   int pattern_age = 0;

   always @(posedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern = '1;
            1: stall_pattern = $urandom();
            2: stall_pattern = $urandom() | $urandom();
            default: stall_pattern = ($urandom() & $urandom()) | 16'h0001;
         endcase
         pattern_age = $urandom_range(16, 80);
      end else begin
         pattern_age--;
      end
      rsp_ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
   end

   // Watch all three channels: predict first, then check the result beat.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            ring_set_limit(csr_data);
            limit_writes++;
         end
         if (req_valid && req_ready) begin
            ring_apply(req_data);
            requests_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("result beat %0d arrived with none expected",
                                         beats_seen));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.data_out !== want.data_out)
                  report_mismatch($sformatf("beat %0d data_out %0d, wanted %0d",
                                            beats_seen, rsp_data.data_out, want.data_out));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("beat %0d status %0d, wanted %0d",
                                            beats_seen, rsp_data.status, want.status));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("beat %0d last %0b, wanted %0b",
                                            beats_seen, rsp_data.last, want.last));
            end
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("circular_queue_engine_unit: mismatch");
         $finish;
      end
   end

   task automatic queue_request(input logic [1:0] kind, input logic [DATA_W-1:0] word);
      req_type item;
      item.kind = kind;
      item.data_in = word;
      pending_req.push_back(item);
      requests_queued++;
   endtask

   // Everything sent has been taken and answered, and a dump has had time to finish.
   task automatic wait_idle();
      while (requests_taken != requests_queued || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIM_W-1:0] value);
      int target;
      wait_idle();
      target = limit_writes + 1;
      @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      wait (limit_writes == target);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [LIM_W-1:0] random_limit();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return LIM_W'(1);
         2: return LIM_W'(DEPTH);
         3: return LIM_W'($urandom_range(DEPTH + 1, 31));
         4, 5, 6, 7: return LIM_W'($urandom_range(2, 6));
         default: return LIM_W'($urandom_range(7, DEPTH));
      endcase
   endfunction

   // A phase leans towards filling or draining so both full and empty are reached.
   task automatic run_random_phase();
      int count;
      int enq_weight;
      int pick;
      count = $urandom_range(12, 30);
      enq_weight = $urandom_range(30, 85);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            queue_request(KIND_UNUSED, $urandom());
         end else begin
            random_items++;
            if (pick < enq_weight)
               queue_request(KIND_ENQ, random_word());
            else if (pick < enq_weight + (100 - enq_weight) * 2 / 3)
               queue_request(KIND_DEQ, $urandom());
            else
               queue_request(KIND_DUMP, $urandom());
         end
      end
   endtask

   initial begin
      ring_set_limit(LIM_W'(DEPTH));
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty queue at reset, an ignored kind, extreme words, a dump and a full drain.
      queue_request(KIND_DEQ, $urandom());
      queue_request(KIND_DUMP, $urandom());
      queue_request(KIND_UNUSED, $urandom());
      queue_request(KIND_ENQ, 32'h7fff_ffff);
      queue_request(KIND_ENQ, 32'h8000_0000);
      queue_request(KIND_ENQ, '1);
      queue_request(KIND_ENQ, '0);
      queue_request(KIND_DUMP, $urandom());
      repeat (4) queue_request(KIND_DEQ, $urandom());
      queue_request(KIND_DEQ, $urandom());

      // A zero limit behaves as a single slot.
      write_limit('0);
      queue_request(KIND_ENQ, random_word());
      queue_request(KIND_ENQ, random_word());
      queue_request(KIND_DUMP, $urandom());
      queue_request(KIND_DEQ, $urandom());
      queue_request(KIND_DUMP, $urandom());

      // Three slots: overflow, then wrap the tail and dump across the wrap.
      write_limit(LIM_W'(3));
      repeat (4) queue_request(KIND_ENQ, random_word());
      queue_request(KIND_DEQ, $urandom());
      queue_request(KIND_ENQ, random_word());
      queue_request(KIND_DUMP, $urandom());
      queue_request(KIND_DEQ, $urandom());

      // Rewriting the limit with words held must leave the queue empty.
      write_limit('1);
      queue_request(KIND_DEQ, $urandom());
      queue_request(KIND_DUMP, $urandom());

      while (random_items < RANDOM_ITEMS) begin
         write_limit(random_limit());
         run_random_phase();
      end

      wait_idle();
      if (expected_rsp.size() != 0)
         report_mismatch($sformatf("%0d result beats never arrived", expected_rsp.size()));
      if (mismatches == 0)
         $display("circular_queue_engine_unit: match");
      else
         $display("circular_queue_engine_unit: mismatch");
      $finish;
   end

endmodule
